/* rtl/core/hpf_pkg.sv */
// Shared types and constants for the hysteresis pulse finder.
package hpf_pkg;

    localparam int SAMPLE_W    = 14;
    localparam int IDX_W       = 13;
    localparam int AREA_W      = 27;
    localparam int PE_W        = 29;
    localparam int SIGMA_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int FRAC_W      = 4;
    localparam int LEVEL_W     = SAMPLE_W + FRAC_W;
    localparam int SIGMUL_W    = SIGMA_W + 3;
    localparam int THR_W       = SIGMUL_W + 2;
    localparam int PROD_W      = AREA_W + SCALE_W;
    localparam int PE_SHIFT    = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 112;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [SIGMUL_W-1:0] START_MULT  = SIGMUL_W'(5);
    localparam logic [SIGMUL_W-1:0] END_MULT    = SIGMUL_W'(3);
    localparam logic [SIGMUL_W-1:0] START_FLOOR = SIGMUL_W'(5 << FRAC_W);
    localparam logic [SIGMUL_W-1:0] END_FLOOR   = SIGMUL_W'(2 << FRAC_W);

    localparam logic [IDX_W-1:0]    IDX_MAX  = {IDX_W{1'b1}};
    localparam logic [AREA_W-1:0]   AREA_MAX = {AREA_W{1'b1}};
    localparam logic [PE_W-1:0]     PE_MAX   = {PE_W{1'b1}};

    localparam logic [SAMPLE_W-1:0] BASELINE_RESET = SAMPLE_W'(8000);
    localparam logic [SIGMA_W-1:0]  SIGMA_RESET    = SIGMA_W'(32);
    localparam logic [SCALE_W-1:0]  SCALE_RESET    = SCALE_W'(988);

    localparam logic [1:0] REG_BASELINE = 2'd0;
    localparam logic [1:0] REG_SIGMA    = 2'd1;
    localparam logic [1:0] REG_SCALE    = 2'd2;

    typedef struct packed {
        logic                pulse_valid;
        logic [IDX_W-1:0]    start_index;
        logic [IDX_W-1:0]    end_index;
        logic [IDX_W-1:0]    peak_index;
        logic [SAMPLE_W-1:0] peak_height;
        logic [AREA_W-1:0]   pulse_area;
        logic                waveform_done;
    } pulse_rec_t;

endpackage

/* rtl/core/hpf_tracker.sv */
// Threshold compare, pulse tracking state and pending pulse record.
module hpf_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          stage_en,
    input  logic                          item_step,
    input  logic [hpf_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          last_sample,
    input  logic [hpf_pkg::SAMPLE_W-1:0]  baseline_level,
    input  logic [hpf_pkg::SIGMA_W-1:0]   baseline_sigma_q4,
    output logic                          rec_valid,
    output hpf_pkg::pulse_rec_t           rec
);

    logic signed [hpf_pkg::THR_W-1:0] thr_start_reg, thr_start_next;
    logic signed [hpf_pkg::THR_W-1:0] thr_end_reg, thr_end_next;
    logic [hpf_pkg::SIGMUL_W-1:0]     sig5, sig3, off_start, off_end;
    logic [hpf_pkg::LEVEL_W-1:0]      base16;

    logic                          in_pulse_reg, in_pulse_next;
    logic [hpf_pkg::IDX_W-1:0]     count_reg, count_next;
    logic [hpf_pkg::IDX_W-1:0]     held_reg, held_next;
    logic [hpf_pkg::AREA_W-1:0]    area_reg, area_next;
    logic [hpf_pkg::SAMPLE_W-1:0]  peak_reg, peak_next;
    logic [hpf_pkg::IDX_W-1:0]     peak_idx_reg, peak_idx_next;
    logic                          rec_valid_reg, rec_valid_next;
    hpf_pkg::pulse_rec_t           rec_reg, rec_next;

    logic signed [hpf_pkg::THR_W-1:0] s16;
    logic                          open_hit, in1, close_hit, in2;
    logic [hpf_pkg::IDX_W-1:0]     start1;
    logic [hpf_pkg::SAMPLE_W-1:0]  diff;
    logic [hpf_pkg::AREA_W:0]      area_sum;
    logic [hpf_pkg::AREA_W-1:0]    area2;
    logic                          peak_up;
    logic [hpf_pkg::SAMPLE_W-1:0]  peak2;
    logic [hpf_pkg::IDX_W-1:0]     peak_idx2;

    always_comb begin
        base16    = {baseline_level, hpf_pkg::FRAC_W'(0)};
        sig5      = hpf_pkg::SIGMUL_W'(baseline_sigma_q4) * hpf_pkg::START_MULT;
        sig3      = hpf_pkg::SIGMUL_W'(baseline_sigma_q4) * hpf_pkg::END_MULT;
        off_start = (sig5 > hpf_pkg::START_FLOOR) ? sig5 : hpf_pkg::START_FLOOR;
        off_end   = (sig3 > hpf_pkg::END_FLOOR) ? sig3 : hpf_pkg::END_FLOOR;
        thr_start_next = $signed(hpf_pkg::THR_W'(base16)) - $signed(hpf_pkg::THR_W'(off_start));
        thr_end_next   = $signed(hpf_pkg::THR_W'(base16)) - $signed(hpf_pkg::THR_W'(off_end));
    end

    always_comb begin
        s16       = $signed(hpf_pkg::THR_W'({sample, hpf_pkg::FRAC_W'(0)}));
        open_hit  = !in_pulse_reg && (s16 <= thr_start_reg);
        in1       = in_pulse_reg || open_hit;
        start1    = open_hit ? ((count_reg > hpf_pkg::IDX_W'(1)) ?
                                count_reg - hpf_pkg::IDX_W'(1) : count_reg)
                             : held_reg;
        close_hit = in1 && (s16 > thr_end_reg);
        in2       = in1 && !close_hit;
        diff      = (baseline_level > sample) ? baseline_level - sample : '0;
        area_sum  = {1'b0, area_reg} + (hpf_pkg::AREA_W + 1)'(diff);
        area2     = area_sum[hpf_pkg::AREA_W] ? hpf_pkg::AREA_MAX
                                              : area_sum[hpf_pkg::AREA_W-1:0];
        peak_up   = diff > peak_reg;
        peak2     = peak_up ? diff : peak_reg;
        peak_idx2 = peak_up ? count_reg : peak_idx_reg;
    end

    always_comb begin
        in_pulse_next  = in_pulse_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        area_next      = area_reg;
        peak_next      = peak_reg;
        peak_idx_next  = peak_idx_reg;
        rec_valid_next = rec_valid_reg;
        rec_next       = rec_reg;
        if (stage_en) begin
            rec_valid_next = item_step && (close_hit || last_sample);
            rec_next       = '0;
            if (close_hit) begin
                rec_next.pulse_valid = 1'b1;
                rec_next.start_index = start1;
                rec_next.end_index   = count_reg;
                rec_next.peak_index  = peak_idx_reg;
                rec_next.peak_height = peak_reg;
                rec_next.pulse_area  = area_reg;
            end else if (in2) begin
                rec_next.pulse_valid = 1'b1;
                rec_next.start_index = start1;
                rec_next.end_index   = count_reg;
                rec_next.peak_index  = peak_idx2;
                rec_next.peak_height = peak2;
                rec_next.pulse_area  = area2;
            end
            rec_next.waveform_done = last_sample;
        end
        if (item_step) begin
            if (last_sample) begin
                in_pulse_next = 1'b0;
                count_next    = '0;
                held_next     = '0;
                area_next     = '0;
                peak_next     = '0;
                peak_idx_next = '0;
            end else begin
                in_pulse_next = in2;
                count_next    = (count_reg == hpf_pkg::IDX_MAX) ? count_reg
                                                                : count_reg + hpf_pkg::IDX_W'(1);
                held_next     = in2 ? start1 : '0;
                area_next     = in2 ? area2 : '0;
                peak_next     = in2 ? peak2 : '0;
                peak_idx_next = in2 ? peak_idx2 : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        thr_start_reg <= thr_start_next;
        thr_end_reg   <= thr_end_next;
        rec_reg       <= rec_next;
        if (!aresetn) begin
            in_pulse_reg  <= 1'b0;
            count_reg     <= '0;
            held_reg      <= '0;
            area_reg      <= '0;
            peak_reg      <= '0;
            peak_idx_reg  <= '0;
            rec_valid_reg <= 1'b0;
        end else begin
            in_pulse_reg  <= in_pulse_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            area_reg      <= area_next;
            peak_reg      <= peak_next;
            peak_idx_reg  <= peak_idx_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

/* rtl/core/hpf_scaler.sv */
// Photoelectron scaling of the pulse area and the result output register.
module hpf_scaler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rec_valid,
    input  hpf_pkg::pulse_rec_t                rec,
    input  logic [hpf_pkg::SCALE_W-1:0]        pe_per_area_q16,
    output logic                               rec_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hpf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic [hpf_pkg::PROD_W-1:0]      prod;
    logic [hpf_pkg::PE_W-1:0]        pe;
    logic                            take;
    logic                            valid_reg, valid_next;
    logic [hpf_pkg::OUT_TDATA_W-1:0] data_reg, data_next;
    logic                            user_reg, user_next;
    logic                            last_reg, last_next;

    always_comb begin
        prod = hpf_pkg::PROD_W'(rec.pulse_area) * hpf_pkg::PROD_W'(pe_per_area_q16);
        pe   = (|prod[hpf_pkg::PROD_W-1:hpf_pkg::PE_W+hpf_pkg::PE_SHIFT]) ? hpf_pkg::PE_MAX
             : prod[hpf_pkg::PE_W+hpf_pkg::PE_SHIFT-1:hpf_pkg::PE_SHIFT];
    end

    assign rec_ready = !valid_reg || m_tready;
    assign take      = rec_valid && rec_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (rec_ready) begin
            valid_next = rec_valid;
        end
        if (take) begin
            data_next = hpf_pkg::OUT_TDATA_W'({pe, rec.pulse_area, rec.peak_height,
                                               rec.peak_index, rec.end_index,
                                               rec.start_index});
            user_next = rec.pulse_valid;
            last_next = rec.waveform_done;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/hysteresis_pulse_finder.sv */
// Hysteresis pulse finder top level: sample input register, register port, core.
//
// One ADC sample is taken every clock cycle while s_tready is high. A sample passes
// an input register, the tracking stage (threshold compares, area and peak update)
// and the scaling stage (27x16 area multiply), each of which is registered. A result
// is sent when a pulse closes and on every last sample of a waveform; a result with
// tuser low and tlast high reports a waveform with no open pulse. Thresholds are
// registered from the register values. Stalls on the result side stop the pipeline
// only once all its stages are full.
module hysteresis_pulse_finder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hpf_pkg::IN_TDATA_W-1:0]     s_tdata,    // sample[13:0]
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // start_index, end_index, peak_index, peak_height, pulse_area, pulse_pe_q8
    output logic [hpf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser,    // pulse_valid
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hpf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hpf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hpf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [hpf_pkg::SAMPLE_W-1:0] baseline_reg, baseline_next;
    logic [hpf_pkg::SIGMA_W-1:0]  sigma_reg, sigma_next;
    logic [hpf_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic                         wr_en;

    logic                         in_valid_reg, in_valid_next;
    logic [hpf_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                         last_reg, last_next;
    logic                         s_take, stage_en, item_step;

    logic                         rec_valid, rec_ready;
    hpf_pkg::pulse_rec_t          rec;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        baseline_next = baseline_reg;
        sigma_next    = sigma_reg;
        scale_next    = scale_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                hpf_pkg::REG_BASELINE: baseline_next = pwdata[hpf_pkg::SAMPLE_W-1:0];
                hpf_pkg::REG_SIGMA:    sigma_next    = pwdata[hpf_pkg::SIGMA_W-1:0];
                hpf_pkg::REG_SCALE:    scale_next    = pwdata[hpf_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hpf_pkg::REG_BASELINE: prdata = hpf_pkg::APB_DATA_W'(baseline_reg);
            hpf_pkg::REG_SIGMA:    prdata = hpf_pkg::APB_DATA_W'(sigma_reg);
            hpf_pkg::REG_SCALE:    prdata = hpf_pkg::APB_DATA_W'(scale_reg);
            default:               prdata = '0;
        endcase
    end

    assign stage_en  = !rec_valid || rec_ready;
    assign item_step = in_valid_reg && stage_en;
    assign s_tready  = !in_valid_reg || stage_en;
    assign s_take    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            sample_next   = s_tdata[hpf_pkg::SAMPLE_W-1:0];
            last_next     = s_tlast;
        end else if (stage_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        if (!aresetn) begin
            baseline_reg <= hpf_pkg::BASELINE_RESET;
            sigma_reg    <= hpf_pkg::SIGMA_RESET;
            scale_reg    <= hpf_pkg::SCALE_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            baseline_reg <= baseline_next;
            sigma_reg    <= sigma_next;
            scale_reg    <= scale_next;
            in_valid_reg <= in_valid_next;
        end
    end

    hpf_tracker u_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .stage_en          (stage_en),
        .item_step         (item_step),
        .sample            (sample_reg),
        .last_sample       (last_reg),
        .baseline_level    (baseline_reg),
        .baseline_sigma_q4 (sigma_reg),
        .rec_valid         (rec_valid),
        .rec               (rec)
    );

    hpf_scaler u_scaler (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rec_valid       (rec_valid),
        .rec             (rec),
        .pe_per_area_q16 (scale_reg),
        .rec_ready       (rec_ready),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

    a_nopulse_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("result without pulse outside waveform end");

    a_nopulse_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty result carries nonzero fields");

    a_start_before_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[12:0] <= m_tdata[25:13]))
        else $error("pulse start after pulse end");

    a_record_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_valid && !rec_ready) |=> (rec_valid && $stable(rec)))
        else $error("pending pulse record lost under stall");

endmodule

/* dv/hysteresis_pulse_finder_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hysteresis pulse finder with a pulse tracker model.
module hysteresis_pulse_finder_test;

    localparam int START_LSB  = 0;
    localparam int END_LSB    = hpf_pkg::IDX_W;
    localparam int PKIDX_LSB  = 2 * hpf_pkg::IDX_W;
    localparam int HEIGHT_LSB = 3 * hpf_pkg::IDX_W;
    localparam int AREA_LSB   = HEIGHT_LSB + hpf_pkg::SAMPLE_W;
    localparam int PE_LSB     = AREA_LSB + hpf_pkg::AREA_W;
    localparam int SAMPLE_MAX = (1 << hpf_pkg::SAMPLE_W) - 1;
    localparam int LONG_WAVE  = 132;

    typedef struct packed {
        bit                         pulse_valid;
        bit [hpf_pkg::IDX_W-1:0]    start_index;
        bit [hpf_pkg::IDX_W-1:0]    end_index;
        bit [hpf_pkg::IDX_W-1:0]    peak_index;
        bit [hpf_pkg::SAMPLE_W-1:0] peak_height;
        bit [hpf_pkg::AREA_W-1:0]   pulse_area;
        bit [hpf_pkg::PE_W-1:0]     pulse_pe_q8;
        bit                         waveform_done;
    } pulse_report_t;

    typedef struct packed {
        bit [hpf_pkg::SAMPLE_W-1:0] sample;
        bit                         last;
        bit                         typed;
        pulse_report_t              want;
    } dir_row_t;

    localparam pulse_report_t EMPTY_END = '{waveform_done: 1'b1, default: '0};

    // reset thresholds: open at or below 7990, close above 7994
    localparam dir_row_t DIR_ROWS [19] = '{
        '{14'd8000,  1'b0, 1'b0, '0},
        '{14'd7990,  1'b0, 1'b0, '0},
        '{14'd0,     1'b0, 1'b0, '0},
        '{14'd16383, 1'b0, 1'b0, '0},
        '{14'd7994,  1'b0, 1'b0, '0},
        '{14'd7991,  1'b0, 1'b0, '0},
        '{14'd7990,  1'b0, 1'b0, '0},
        '{14'd7994,  1'b0, 1'b0, '0},
        '{14'd7990,  1'b0, 1'b0, '0},
        '{14'd7995,  1'b0, 1'b0, '0},
        '{14'd7000,  1'b1, 1'b0, '0},
        '{14'd8000,  1'b1, 1'b1, EMPTY_END},
        '{14'd0,     1'b0, 1'b0, '0},
        '{14'd16383, 1'b1, 1'b0, '0},
        '{14'd16383, 1'b0, 1'b0, '0},
        '{14'd0,     1'b0, 1'b0, '0},
        '{14'd0,     1'b0, 1'b0, '0},
        '{14'd0,     1'b1, 1'b0, '0},
        '{14'd12345, 1'b1, 1'b1, EMPTY_END}
    };

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hpf_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [hpf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [hpf_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [hpf_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [hpf_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    logic [hpf_pkg::SAMPLE_W-1:0] cfg_baseline = hpf_pkg::BASELINE_RESET;
    logic [hpf_pkg::SIGMA_W-1:0]  cfg_sigma    = hpf_pkg::SIGMA_RESET;
    logic [hpf_pkg::SCALE_W-1:0]  cfg_scale    = hpf_pkg::SCALE_RESET;

    bit                         pf_open;
    bit [hpf_pkg::IDX_W-1:0]    pf_index;
    bit [hpf_pkg::IDX_W-1:0]    pf_start;
    bit [hpf_pkg::AREA_W-1:0]   pf_area;
    bit [hpf_pkg::SAMPLE_W-1:0] pf_peak;
    bit [hpf_pkg::IDX_W-1:0]    pf_peak_idx;

    pulse_report_t pending_reports[$];
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;

    hysteresis_pulse_finder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    function automatic pulse_report_t report_pulse(input bit [hpf_pkg::IDX_W-1:0] end_idx);
        pulse_report_t r;
        longint        pe;
        pe = (longint'(pf_area) * longint'(cfg_scale)) >> hpf_pkg::PE_SHIFT;
        r = '0;
        r.pulse_valid = 1'b1;
        r.start_index = pf_start;
        r.end_index   = end_idx;
        r.peak_index  = pf_peak_idx;
        r.peak_height = pf_peak;
        r.pulse_area  = pf_area;
        r.pulse_pe_q8 = (pe > longint'(hpf_pkg::PE_MAX)) ? hpf_pkg::PE_MAX
                                                        : hpf_pkg::PE_W'(pe);
        return r;
    endfunction

    function automatic void clear_pulse_state();
        pf_open     = 1'b0;
        pf_start    = '0;
        pf_area     = '0;
        pf_peak     = '0;
        pf_peak_idx = '0;
    endfunction

    function automatic bit track_sample(input bit [hpf_pkg::SAMPLE_W-1:0] s,
                                        input bit last, output pulse_report_t rep);
        int                      base16, s16, sig5, sig3, thr_start, thr_end, depth;
        bit [hpf_pkg::IDX_W-1:0] idx;
        bit                      found;
        idx       = pf_index;
        base16    = int'(cfg_baseline) * 16;
        s16       = int'(s) * 16;
        sig5      = int'(cfg_sigma) * 5;
        sig3      = int'(cfg_sigma) * 3;
        thr_start = base16 - ((sig5 > 80) ? sig5 : 80);
        thr_end   = base16 - ((sig3 > 32) ? sig3 : 32);
        rep       = '0;
        found     = 1'b0;
        if (!pf_open && s16 <= thr_start) begin
            pf_open  = 1'b1;
            pf_start = (idx > 1) ? idx - 1'b1 : idx;
        end
        if (pf_open && s16 > thr_end) begin
            rep   = report_pulse(idx);
            found = 1'b1;
            clear_pulse_state();
        end
        if (pf_open) begin
            depth = int'(cfg_baseline) - int'(s);
            if (depth < 0)
                depth = 0;
            if (longint'(pf_area) + depth > longint'(hpf_pkg::AREA_MAX))
                pf_area = hpf_pkg::AREA_MAX;
            else
                pf_area = pf_area + hpf_pkg::AREA_W'(depth);
            if (depth > int'(pf_peak)) begin
                pf_peak     = hpf_pkg::SAMPLE_W'(depth);
                pf_peak_idx = idx;
            end
        end
        if (pf_index != hpf_pkg::IDX_MAX)
            pf_index++;
        if (last) begin
            if (pf_open)
                rep = report_pulse(idx);
            rep.waveform_done = 1'b1;
            found    = 1'b1;
            pf_index = '0;
            clear_pulse_state();
        end
        return found;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic send_sample(input bit [hpf_pkg::SAMPLE_W-1:0] s, input bit last,
                               input bit typed = 1'b0, input pulse_report_t want = '0);
        pulse_report_t rep;
        while (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hpf_pkg::IN_TDATA_W'(s);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (track_sample(s, last, rep))
            pending_reports.insert(pending_reports.size(), typed ? want : rep);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] reg_idx,
                                  input logic [hpf_pkg::APB_DATA_W-1:0] value);
        logic [hpf_pkg::APB_DATA_W-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hpf_pkg::APB_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (reg_idx)
            hpf_pkg::REG_BASELINE: begin
                cfg_baseline = value[hpf_pkg::SAMPLE_W-1:0];
                stored = hpf_pkg::APB_DATA_W'(cfg_baseline);
            end
            hpf_pkg::REG_SIGMA: begin
                cfg_sigma = value[hpf_pkg::SIGMA_W-1:0];
                stored = hpf_pkg::APB_DATA_W'(cfg_sigma);
            end
            default: begin
                cfg_scale = value[hpf_pkg::SCALE_W-1:0];
                stored = hpf_pkg::APB_DATA_W'(cfg_scale);
            end
        endcase
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("prdata", stored, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int baseline, input int sigma, input int scale);
        write_register(hpf_pkg::REG_BASELINE, hpf_pkg::APB_DATA_W'(baseline));
        write_register(hpf_pkg::REG_SIGMA, hpf_pkg::APB_DATA_W'(sigma));
        write_register(hpf_pkg::REG_SCALE, hpf_pkg::APB_DATA_W'(scale));
    endtask

    task automatic run_waveforms(input int budget);
        int first_item, len, depth, open_depth, hold_depth, v5, v3, left, v;
        bit chaotic;
        first_item = sent_items;
        while (sent_items - first_item < budget) begin
            len        = int'($urandom_range(1, 48));
            chaotic    = ($urandom_range(9) == 0);
            v5         = int'(cfg_sigma) * 5;
            v3         = int'(cfg_sigma) * 3;
            open_depth = (((v5 > 80) ? v5 : 80) + 15) / 16;
            hold_depth = (((v3 > 32) ? v3 : 32) + 15) / 16;
            left       = 0;
            for (int i = 0; i < len; i++) begin
                if (left == 0 && $urandom_range(7) == 0)
                    left = int'($urandom_range(1, 12));
                if (chaotic) begin
                    v = int'($urandom_range(SAMPLE_MAX));
                end else if (left > 0) begin
                    case ($urandom_range(4))
                        0:       depth = open_depth + int'($urandom_range(2)) - 1;
                        1:       depth = hold_depth + int'($urandom_range(1)) - 1;
                        2:       depth = int'($urandom_range(int'(cfg_baseline)));
                        3:       depth = int'(cfg_baseline);
                        default: depth = open_depth + int'($urandom_range(200));
                    endcase
                    v = int'(cfg_baseline) - depth;
                    left--;
                end else begin
                    v = int'(cfg_baseline) + int'($urandom_range(2 * hold_depth)) - hold_depth;
                end
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                send_sample(hpf_pkg::SAMPLE_W'(v), i == len - 1);
            end
        end
    endtask

    always @(negedge aclk)
        m_tready <= (recv_stall_pct == 0) || (int'($urandom_range(99)) >= recv_stall_pct);

    always @(posedge aclk) begin : result_check
        pulse_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result transfer with no result pending");
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("pulse_valid", want.pulse_valid, m_tuser);
                check_field("start_index", want.start_index,
                            m_tdata[START_LSB +: hpf_pkg::IDX_W]);
                check_field("end_index", want.end_index,
                            m_tdata[END_LSB +: hpf_pkg::IDX_W]);
                check_field("peak_index", want.peak_index,
                            m_tdata[PKIDX_LSB +: hpf_pkg::IDX_W]);
                check_field("peak_height", want.peak_height,
                            m_tdata[HEIGHT_LSB +: hpf_pkg::SAMPLE_W]);
                check_field("pulse_area", want.pulse_area,
                            m_tdata[AREA_LSB +: hpf_pkg::AREA_W]);
                check_field("pulse_pe_q8", want.pulse_pe_q8,
                            m_tdata[PE_LSB +: hpf_pkg::PE_W]);
                check_field("waveform_done", want.waveform_done, m_tlast);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIR_ROWS[r])
            send_sample(DIR_ROWS[r].sample, DIR_ROWS[r].last,
                        DIR_ROWS[r].typed, DIR_ROWS[r].want);
        drain();

        set_config(0, 0, 0);
        run_waveforms(20);
        drain();
        set_config(SAMPLE_MAX, 65535, 65535);
        run_waveforms(20);
        drain();

        // saturate PE in one long waveform
        set_config(SAMPLE_MAX, 0, 65535);
        for (int i = 0; i < LONG_WAVE; i++)
            send_sample('0, i == LONG_WAVE - 1);
        run_waveforms(10);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case ($urandom_range(3))
                0:       set_config(int'($urandom_range(200, SAMPLE_MAX)),
                                    int'($urandom_range(15)), int'($urandom_range(65535)));
                1:       set_config(int'($urandom_range(200, SAMPLE_MAX)),
                                    int'($urandom_range(16, 160)), int'($urandom_range(65535)));
                2:       set_config(int'($urandom_range(200, SAMPLE_MAX)),
                                    int'($urandom_range(160, 2000)), int'($urandom_range(65535)));
                default: set_config(int'($urandom_range(SAMPLE_MAX)),
                                    int'($urandom_range(65535)), int'($urandom_range(65535)));
            endcase
            run_waveforms(20);
            drain();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
